/* design/i2c_mbs_pkg.sv */
// ----------------------------------------------------------------------------
// I2C master bit sequencer package
// Shared request codes, pin command types and sizes.
// ----------------------------------------------------------------------------
package i2c_mbs_pkg;

  // Bits in one bus byte
  localparam int unsigned BitsPerByte = 8;
  localparam int unsigned BitCntW     = $clog2(BitsPerByte);

  // Field widths
  localparam int unsigned ReqW  = 3;
  localparam int unsigned ByteW = 8;

  // Request codes
  localparam logic [ReqW-1:0] REQ_START   = 3'd0;
  localparam logic [ReqW-1:0] REQ_STOP    = 3'd1;
  localparam logic [ReqW-1:0] REQ_TX_BYTE = 3'd2;
  localparam logic [ReqW-1:0] REQ_RX_BYTE = 3'd3;
  localparam logic [ReqW-1:0] REQ_TX_ACK  = 3'd4;
  localparam logic [ReqW-1:0] REQ_RX_ACK  = 3'd5;

  // Level driven by one pin write
  typedef enum logic [1:0] {
    LVL_ZERO = 2'd0,
    LVL_ONE  = 2'd1,
    LVL_TX   = 2'd2,
    LVL_ACK  = 2'd3
  } lvl_sel_e;

  // Received value shown with a result
  typedef enum logic [1:0] {
    RX_NONE = 2'd0,
    RX_BYTE = 2'd1,
    RX_ACK  = 2'd2
  } rx_sel_e;

  // Controller to datapath command
  typedef struct packed {
    logic     load;     // capture the request fields
    logic     emit;     // perform one pin write and produce a result
    logic     pin_scl;  // 1 writes the clock line, 0 the data line
    lvl_sel_e lvl_sel;
    rx_sel_e  rx_sel;
    logic     last;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;     // output register can take a result this cycle
  } dp_status_t;

endpackage

/* design/i2c_mbs_ctrl.sv */
// ----------------------------------------------------------------------------
// I2C master bit sequencer controller
// Walks the pin write sequence of one request and commands the datapath.
// ----------------------------------------------------------------------------
module i2c_mbs_ctrl
  import i2c_mbs_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  output logic            req_ready_o,
  input  logic [ReqW-1:0] req_type_i,
  input  dp_status_t      status_i,
  output dp_cmd_t         cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic               state_q, state_d;
  logic [ReqW-1:0]    req_q, req_d;
  logic [1:0]         ph_q, ph_d;
  logic [BitCntW-1:0] bc_q, bc_d;
  logic               fire;
  logic               last_bit;

  assign req_ready_o = (state_q == ST_IDLE);
  assign fire        = (state_q == ST_RUN) && status_i.out_free;
  assign last_bit    = (bc_q == BitCntW'(BitsPerByte - 1));

  // Decode the current step of the request
  always_comb begin
    cmd_o         = '0;
    cmd_o.lvl_sel = LVL_ZERO;
    cmd_o.rx_sel  = RX_NONE;
    cmd_o.load    = req_valid_i && (state_q == ST_IDLE);
    cmd_o.emit    = fire;
    case (req_q)
      REQ_START: begin
        case (ph_q)
          2'd0: cmd_o.lvl_sel = LVL_ONE;
          2'd1: begin
            cmd_o.pin_scl = 1'b1;
            cmd_o.lvl_sel = LVL_ONE;
          end
          2'd2: cmd_o.lvl_sel = LVL_ZERO;
          default: begin
            cmd_o.pin_scl = 1'b1;
            cmd_o.last    = 1'b1;
          end
        endcase
      end
      REQ_STOP: begin
        case (ph_q)
          2'd0: cmd_o.lvl_sel = LVL_ZERO;
          2'd1: begin
            cmd_o.pin_scl = 1'b1;
            cmd_o.lvl_sel = LVL_ONE;
          end
          default: begin
            cmd_o.lvl_sel = LVL_ONE;
            cmd_o.last    = 1'b1;
          end
        endcase
      end
      REQ_TX_BYTE, REQ_RX_BYTE, REQ_TX_ACK, REQ_RX_ACK: begin
        case (ph_q)
          2'd0: begin
            if (req_q == REQ_TX_BYTE) begin
              cmd_o.lvl_sel = LVL_TX;
            end else if (req_q == REQ_TX_ACK) begin
              cmd_o.lvl_sel = LVL_ACK;
            end else begin
              cmd_o.lvl_sel = LVL_ONE;
            end
          end
          2'd1: begin
            cmd_o.pin_scl = 1'b1;
            cmd_o.lvl_sel = LVL_ONE;
          end
          default: begin
            cmd_o.pin_scl = 1'b1;
            if (req_q == REQ_TX_ACK) begin
              cmd_o.last = 1'b1;
            end else if (req_q == REQ_RX_ACK) begin
              cmd_o.last   = 1'b1;
              cmd_o.rx_sel = RX_ACK;
            end else if (last_bit) begin
              cmd_o.last = 1'b1;
              if (req_q == REQ_RX_BYTE) begin
                cmd_o.rx_sel = RX_BYTE;
              end
            end
          end
        endcase
      end
      default: ;
    endcase
  end

  // Advance the step counters
  always_comb begin
    state_d = state_q;
    req_d   = req_q;
    ph_d    = ph_q;
    bc_d    = bc_q;
    if (state_q == ST_IDLE) begin
      if (req_valid_i && (req_type_i inside {[REQ_START:REQ_RX_ACK]})) begin
        state_d = ST_RUN;
        req_d   = req_type_i;
        ph_d    = 2'd0;
        bc_d    = '0;
      end
    end else if (fire) begin
      if (cmd_o.last) begin
        state_d = ST_IDLE;
        ph_d    = 2'd0;
        bc_d    = '0;
      end else if ((ph_q == 2'd2) && (req_q == REQ_TX_BYTE)) begin
        ph_d = 2'd0;
        bc_d = bc_q + 1'b1;
      end else if ((ph_q == 2'd2) && (req_q == REQ_RX_BYTE)) begin
        // data line stays released, loop on clock high and low only
        ph_d = 2'd1;
        bc_d = bc_q + 1'b1;
      end else begin
        ph_d = ph_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      req_q   <= REQ_START;
      ph_q    <= 2'd0;
      bc_q    <= '0;
    end else begin
      state_q <= state_d;
      req_q   <= req_d;
      ph_q    <= ph_d;
      bc_q    <= bc_d;
    end
  end

  // Last write of a request returns the controller to idle
  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit && cmd_o.last |=> state_q == ST_IDLE)
    else $error("controller did not go idle after the last write");

  // No pin writes while idle
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !cmd_o.emit)
    else $error("pin write issued while idle");

  // Bit counter moves only for byte requests
  a_bc_bytes_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_q != REQ_TX_BYTE) && (req_q != REQ_RX_BYTE) |-> bc_q == '0)
    else $error("bit counter moved outside a byte request");

endmodule

/* design/i2c_mbs_dp.sv */
// ----------------------------------------------------------------------------
// I2C master bit sequencer datapath
// Holds the pin levels, the request fields and the output register.
// ----------------------------------------------------------------------------
module i2c_mbs_dp
  import i2c_mbs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dp_cmd_t          cmd_i,
  output dp_status_t       status_o,
  input  logic [ByteW-1:0] tx_value_i,
  input  logic             ack_out_i,
  input  logic [ByteW-1:0] line_bits_i,
  input  logic             line_ack_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             scl_o,
  output logic             sda_o,
  output logic [ByteW-1:0] rx_value_o,
  output logic             last_o
);

  logic             scl_q, sda_q;
  logic [ByteW-1:0] tx_q, lines_q;
  logic             ack_q, lack_q;
  logic             out_valid_q;
  logic             out_scl_q, out_sda_q, out_last_q;
  logic [ByteW-1:0] out_rx_q;
  logic             lvl;
  logic [ByteW-1:0] rx;

  assign status_o.out_free = !out_valid_q || out_ready_i;

  // Select the level for this write
  always_comb begin
    case (cmd_i.lvl_sel)
      LVL_ZERO: lvl = 1'b0;
      LVL_ONE:  lvl = 1'b1;
      LVL_TX:   lvl = tx_q[ByteW-1];
      LVL_ACK:  lvl = ack_q;
      default:  lvl = 1'b1;
    endcase
  end

  // Select the received value shown with this write
  always_comb begin
    case (cmd_i.rx_sel)
      RX_BYTE: rx = lines_q;
      RX_ACK:  rx = {{(ByteW-1){1'b0}}, lack_q};
      default: rx = '0;
    endcase
  end

  // Pin levels and output handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.emit) begin
        if (cmd_i.pin_scl) begin
          scl_q <= lvl;
        end else begin
          sda_q <= lvl;
        end
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture request fields, shift out the send byte, load results
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      tx_q    <= tx_value_i;
      ack_q   <= ack_out_i;
      lines_q <= line_bits_i;
      lack_q  <= line_ack_i;
    end else if (cmd_i.emit && (cmd_i.lvl_sel == LVL_TX)) begin
      tx_q <= {tx_q[ByteW-2:0], 1'b0};
    end
    if (cmd_i.emit) begin
      out_scl_q  <= cmd_i.pin_scl ? lvl : scl_q;
      out_sda_q  <= cmd_i.pin_scl ? sda_q : lvl;
      out_rx_q   <= rx;
      out_last_q <= cmd_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign scl_o       = out_scl_q;
  assign sda_o       = out_sda_q;
  assign rx_value_o  = out_rx_q;
  assign last_o      = out_last_q;

  // Received value only rides on the last write of a request
  a_rx_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_last_q |-> out_rx_q == '0)
    else $error("received value on a non-final write");

  // A clock write leaves the data line alone
  a_scl_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit && cmd_i.pin_scl |=> sda_q == $past(sda_q))
    else $error("data line changed on a clock write");

  // A data write leaves the clock line alone
  a_sda_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit && !cmd_i.pin_scl |=> scl_q == $past(scl_q))
    else $error("clock line changed on a data write");

endmodule

/* design/i2c_master_bit_sequencer_core.sv */
// Takes one I2C master request at a time (start, stop, send byte, receive
// byte, send ack, receive ack) and streams one result per pin write, each
// showing the clock and data line after that write. A request is taken only
// when the previous one has issued all of its writes; writes then leave at
// one per cycle while the output is ready. The controller takes a request
// while idle and then steps its sequence, one pin write per step. Unused
// request codes are taken and produce no result. Pin levels persist between
// requests and reset to both lines high.
// ----------------------------------------------------------------------------
// I2C master bit sequencer core
// Top level: stream ports, controller and datapath.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer_core
  import i2c_mbs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tx_value[7:0], ack_out[8], line_bits[16:9], line_ack[17], zero[23:18]
  input  logic [23:0] s_axis_tdata_i,
  // req_type[2:0]
  input  logic [2:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // scl[0], sda[1], rx_value[9:2], zero[15:10]
  output logic [15:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o
);

  dp_cmd_t          cmd;
  dp_status_t       status;
  logic             scl, sda;
  logic [ByteW-1:0] rx_value;

  i2c_mbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid_i),
    .req_ready_o (s_axis_tready_o),
    .req_type_i  (s_axis_tuser_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  i2c_mbs_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .tx_value_i  (s_axis_tdata_i[7:0]),
    .ack_out_i   (s_axis_tdata_i[8]),
    .line_bits_i (s_axis_tdata_i[16:9]),
    .line_ack_i  (s_axis_tdata_i[17]),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .scl_o       (scl),
    .sda_o       (sda),
    .rx_value_o  (rx_value),
    .last_o      (m_axis_tlast_o)
  );

  // Pack the result
  assign m_axis_tdata_o = {6'd0, rx_value, sda, scl};

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit sequencer testbench
// Drives bus requests into the sequencer core and checks every pin write it
// streams out against a local model of the clock and data line levels.
// Directed requests cover each request kind, byte extremes, both acknowledge
// levels and the unused codes; random I2C transactions follow, with idle
// bursts on both sides, one long output hold-off and one drain pause.
// ----------------------------------------------------------------------------
module tb;
  import i2c_mbs_pkg::*;

  localparam int unsigned ClkPeriod   = 20;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainCycles = 50;
  localparam int unsigned NumRequests = 160;

  // Codes the core takes but answers with no pin write
  localparam logic [ReqW-1:0] REQ_RSVD_A = 3'd6;
  localparam logic [ReqW-1:0] REQ_RSVD_B = 3'd7;

  // One pin write as seen on the output stream
  typedef struct packed {
    logic             scl;
    logic             sda;
    logic [ByteW-1:0] rx_value;
    logic             last;
  } pin_write_t;

  // Line-level model and queue of pin writes still owed by the core
  class pin_scoreboard;
    logic       clock_lvl;
    logic       data_lvl;
    pin_write_t owed_writes[$];
    int         errors;

    function new();
      clock_lvl = 1'b1;
      data_lvl  = 1'b1;
      errors    = 0;
    endfunction

    function int pending();
      return owed_writes.size();
    endfunction

    // Record one write of the data line or the clock line
    function void write_pin(bit on_clock, logic lvl);
      pin_write_t w;
      if (on_clock) clock_lvl = lvl;
      else data_lvl = lvl;
      w.scl      = clock_lvl;
      w.sda      = data_lvl;
      w.rx_value = '0;
      w.last     = 1'b0;
      owed_writes.push_back(w);
    endfunction

    // Tag the final write of a request
    function void close_request(logic [ByteW-1:0] rx);
      pin_write_t w;
      w = owed_writes.pop_back();
      w.rx_value = rx;
      w.last     = 1'b1;
      owed_writes.push_back(w);
    endfunction

    // Predict the pin writes of one accepted request
    function void note_request(logic [ReqW-1:0] req, logic [ByteW-1:0] tx_value,
                               logic ack_out, logic [ByteW-1:0] line_bits,
                               logic line_ack);
      case (req)
        REQ_START: begin
          write_pin(0, 1'b1);
          write_pin(1, 1'b1);
          write_pin(0, 1'b0);
          write_pin(1, 1'b0);
          close_request('0);
        end
        REQ_STOP: begin
          write_pin(0, 1'b0);
          write_pin(1, 1'b1);
          write_pin(0, 1'b1);
          close_request('0);
        end
        REQ_TX_BYTE: begin
          for (int i = BitsPerByte - 1; i >= 0; i--) begin
            write_pin(0, tx_value[i]);
            write_pin(1, 1'b1);
            write_pin(1, 1'b0);
          end
          close_request('0);
        end
        REQ_RX_BYTE: begin
          write_pin(0, 1'b1);
          for (int i = 0; i < BitsPerByte; i++) begin
            write_pin(1, 1'b1);
            write_pin(1, 1'b0);
          end
          // the received byte is the line_bits field given with the request
          close_request(line_bits);
        end
        REQ_TX_ACK: begin
          write_pin(0, ack_out);
          write_pin(1, 1'b1);
          write_pin(1, 1'b0);
          close_request('0);
        end
        REQ_RX_ACK: begin
          write_pin(0, 1'b1);
          write_pin(1, 1'b1);
          write_pin(1, 1'b0);
          close_request({{(ByteW - 1){1'b0}}, line_ack});
        end
        default: ;
      endcase
    endfunction

    // Compare one streamed pin write with the oldest owed one
    function void check_write(pin_write_t got);
      pin_write_t want;
      if (owed_writes.size() == 0) begin
        $error("unexpected pin write: scl %0d sda %0d rx_value 0x%02h last %0d",
               got.scl, got.sda, got.rx_value, got.last);
        errors++;
        return;
      end
      want = owed_writes.pop_front();
      if (got.scl !== want.scl) begin
        $error("scl: expected %0d, actual %0d", want.scl, got.scl);
        errors++;
      end
      if (got.sda !== want.sda) begin
        $error("sda: expected %0d, actual %0d", want.sda, got.sda);
        errors++;
      end
      if (got.rx_value !== want.rx_value) begin
        $error("rx_value: expected 0x%02h, actual 0x%02h", want.rx_value, got.rx_value);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, actual %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i;
  logic [2:0]  s_axis_tuser_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [15:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;

  pin_scoreboard sb;
  bit            idle_on;
  bit            hold_out;
  int unsigned   cycle_cnt;
  int unsigned   req_cnt;

  i2c_master_bit_sequencer_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Note accepted requests first, then check streamed pin writes
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (s_axis_tvalid_i && s_axis_tready_o)
        sb.note_request(s_axis_tuser_i, s_axis_tdata_i[7:0], s_axis_tdata_i[8],
                        s_axis_tdata_i[16:9], s_axis_tdata_i[17]);
      if (m_axis_tvalid_o && m_axis_tready_i)
        sb.check_write('{scl: m_axis_tdata_o[0], sda: m_axis_tdata_o[1],
                         rx_value: m_axis_tdata_o[9:2], last: m_axis_tlast_o});
    end
  end

  // Output side: random stall bursts, plus one long hold-off on request
  initial begin
    m_axis_tready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_out) begin
        m_axis_tready_i = 1'b0;
        repeat (HoldCycles - 1) @(negedge clk_i);
        hold_out = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready_i = 1'b0;
        repeat ($urandom_range(1, 4) - 1) @(negedge clk_i);
      end else begin
        m_axis_tready_i = 1'b1;
      end
    end
  end

  // Offer one request and hold it until the core takes it
  task automatic send_cmd(logic [ReqW-1:0] req, logic [ByteW-1:0] tx_value,
                          logic ack_out, logic [ByteW-1:0] line_bits, logic line_ack);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid_i = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tuser_i  = req;
    s_axis_tdata_i  = {6'b0, line_ack, line_bits, ack_out, tx_value};
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
    if (req <= REQ_RX_ACK) req_cnt++;
  endtask

  // Request with random content in every field
  task automatic send_rand(logic [ReqW-1:0] req);
    send_cmd(req, 8'($urandom), 1'($urandom), 8'($urandom), 1'($urandom));
  endtask

  // Hold the input side until the core has streamed everything owed
  task automatic wait_drained();
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  // One random bus transaction: start, address, data phases, optional stop
  task automatic send_transaction();
    logic is_read;
    int   n_bytes;
    is_read = 1'($urandom);
    n_bytes = $urandom_range(1, 4);
    send_rand(REQ_START);
    send_rand(REQ_TX_BYTE);
    send_rand(REQ_RX_ACK);
    for (int i = 0; i < n_bytes; i++) begin
      if (is_read) begin
        send_rand(REQ_RX_BYTE);
        send_rand(REQ_TX_ACK);
      end else begin
        send_rand(REQ_TX_BYTE);
        send_rand(REQ_RX_ACK);
      end
    end
    // leave some transactions open so the next start is a repeated start
    if ($urandom_range(0, 4) != 0) send_rand(REQ_STOP);
  endtask

  // Main sequence
  initial begin
    bit hold_done;
    sb              = new();
    cycle_cnt       = 0;
    req_cnt         = 0;
    idle_on         = 1'b1;
    hold_out        = 1'b0;
    hold_done       = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = '0;
    rst_ni          = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: each request kind, byte extremes, both ack levels, unused codes
    send_cmd(REQ_STOP, 8'h00, 1'b0, 8'h00, 1'b0);
    send_cmd(REQ_START, 8'hFF, 1'b1, 8'hFF, 1'b1);
    send_cmd(REQ_TX_BYTE, 8'h00, 1'b1, 8'hFF, 1'b1);
    send_cmd(REQ_RX_ACK, 8'hFF, 1'b1, 8'hFF, 1'b0);
    send_cmd(REQ_TX_BYTE, 8'hFF, 1'b0, 8'h00, 1'b0);
    send_cmd(REQ_RX_ACK, 8'h00, 1'b0, 8'h00, 1'b1);
    send_cmd(REQ_TX_BYTE, 8'hA5, 1'b0, 8'h3C, 1'b1);
    send_cmd(REQ_START, 8'h00, 1'b0, 8'h00, 1'b0);
    send_cmd(REQ_RX_BYTE, 8'hFF, 1'b1, 8'h00, 1'b1);
    send_cmd(REQ_TX_ACK, 8'hFF, 1'b0, 8'hFF, 1'b1);
    send_cmd(REQ_RX_BYTE, 8'h00, 1'b0, 8'hFF, 1'b0);
    send_cmd(REQ_TX_ACK, 8'h00, 1'b1, 8'h00, 1'b0);
    send_cmd(REQ_RX_BYTE, 8'hC3, 1'b1, 8'h5A, 1'b1);
    send_cmd(REQ_RSVD_A, 8'hFF, 1'b1, 8'hFF, 1'b1);
    send_cmd(REQ_RSVD_B, 8'h00, 1'b0, 8'h00, 1'b0);
    send_cmd(REQ_STOP, 8'hFF, 1'b1, 8'hFF, 1'b1);
    send_cmd(REQ_STOP, 8'h00, 1'b0, 8'h00, 1'b0);
    send_cmd(REQ_TX_ACK, 8'h00, 1'b0, 8'h00, 1'b0);
    send_cmd(REQ_RX_ACK, 8'h00, 1'b0, 8'h00, 1'b0);

    // Pause the sender until every owed pin write is out
    s_axis_tvalid_i = 1'b0;
    wait_drained();

    // Random: mostly well-formed transactions, some noise requests
    while (req_cnt < NumRequests) begin
      if (!hold_done && req_cnt >= 60) begin
        hold_out  = 1'b1;
        hold_done = 1'b1;
      end
      if (req_cnt >= NumRequests - 30) idle_on = 1'b0;
      if ($urandom_range(0, 9) == 0) send_rand(3'($urandom_range(0, 7)));
      else send_transaction();
    end
    s_axis_tvalid_i = 1'b0;

    // Drain, then let any late write surface
    wait_drained();
    repeat (DrainCycles) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* i2c_master_bit_sequencer_core.f */
design/i2c_mbs_pkg.sv
design/i2c_mbs_ctrl.sv
design/i2c_mbs_dp.sv
design/i2c_master_bit_sequencer_core.sv
sim/tb.sv
